>>> rtl/jtnc_pkg.sv
package jtnc_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SAVED_W     = 2;
  localparam int DEPTH_W     = 6;

  // item modes
  localparam logic [1:0] MODE_TOKEN = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  // token kinds
  localparam logic [3:0] TOK_NULL      = 4'd0;
  localparam logic [3:0] TOK_BOOLEAN   = 4'd1;
  localparam logic [3:0] TOK_NUMBER    = 4'd2;
  localparam logic [3:0] TOK_STRING    = 4'd3;
  localparam logic [3:0] TOK_KEY       = 4'd4;
  localparam logic [3:0] TOK_BEGIN_ARR = 4'd5;
  localparam logic [3:0] TOK_END_ARR   = 4'd6;
  localparam logic [3:0] TOK_BEGIN_OBJ = 4'd7;
  localparam logic [3:0] TOK_END_OBJ   = 4'd8;

  // reported state codes
  localparam logic [2:0] CODE_START = 3'd0;
  localparam logic [2:0] CODE_ARRAY = 3'd1;
  localparam logic [2:0] CODE_KEY   = 3'd2;
  localparam logic [2:0] CODE_VALUE = 3'd3;
  localparam logic [2:0] CODE_END   = 3'd4;

  // grammar state, one-hot
  typedef enum logic [4:0] {
    ST_START = 5'b00001,
    ST_ARRAY = 5'b00010,
    ST_KEY   = 5'b00100,
    ST_VALUE = 5'b01000,
    ST_END   = 5'b10000
  } state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] token_kind;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         current_state;
    logic               error_flag;
    logic [DEPTH_W-1:0] nesting_depth;
    logic               overflow;
  } out_item_t;

  // one-hot state to reported code
  function automatic logic [2:0] state_code(state_t s);
    logic [2:0] c;
    unique case (s)
      ST_START: c = CODE_START;
      ST_ARRAY: c = CODE_ARRAY;
      ST_KEY:   c = CODE_KEY;
      ST_VALUE: c = CODE_VALUE;
      ST_END:   c = CODE_END;
      default:  c = CODE_START;
    endcase
    return c;
  endfunction

  // popped code after its value step; a code with no value step gives start
  function automatic state_t pop_state(logic [SAVED_W-1:0] code);
    state_t s;
    unique case (code)
      CODE_START[SAVED_W-1:0]: s = ST_END;
      CODE_ARRAY[SAVED_W-1:0]: s = ST_ARRAY;
      CODE_VALUE[SAVED_W-1:0]: s = ST_KEY;
      default:                 s = ST_START;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/jtnc_ram.sv
module jtnc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/json_token_nesting_checker.sv
// json token nesting checker
// in channel: one item per transfer, a token, a clear-error command or a
// full reset of state and stack. out channel: one result per item with the
// grammar state, the sticky error flag, the nesting depth and an overflow
// bit for a begin token that found the stack full.
// the result is registered and presented in the cycle after the input
// transfer, and is held in the output register until taken.
// throughput: one item per cycle while the receiver does not stall. the
// saved states live in a ram with a registered read; its read address
// always follows the new stack pointer so the top entry is ready for the
// next item, and a push that writes that same entry is forwarded from a register.
// a stalled receiver holds the output register; in_ready then drops until
// the held result is taken, and is high again in the cycle it is taken.
// reset: synchronous active-low rst_n returns the state to start, clears
// the error flag and empties the stack; no clearing pass is needed since
// entries above the stack pointer are never read.
module json_token_nesting_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  jtnc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output jtnc_pkg::out_item_t out_data
);

  jtnc_pkg::state_t                 state_r, state_nxt;
  logic                             err_r, err_nxt;
  logic [jtnc_pkg::SP_W-1:0]        sp_r, sp_nxt, sp_dec;
  logic                             ovf;
  logic                             accept;
  logic                             push, legal;
  logic                             fwd_r;
  logic [jtnc_pkg::SAVED_W-1:0]     fwd_data_r, wr_data, rd_data, top;
  logic [2:0]                       cur_code;
  logic [jtnc_pkg::ADDR_W-1:0]      wr_addr, rd_addr;
  logic                             full, empty;
  logic                             out_valid_r;
  jtnc_pkg::out_item_t              out_data_r;

  assign accept = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign full  = (sp_r == jtnc_pkg::SP_W'(jtnc_pkg::STACK_DEPTH));
  assign empty = (sp_r == '0);
  assign top   = fwd_r ? fwd_data_r : rd_data;

  // grammar transition
  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    sp_nxt    = sp_r;
    ovf       = 1'b0;
    push      = 1'b0;
    legal     = 1'b0;
    if (accept) begin
      priority if (in_data.mode == jtnc_pkg::MODE_RESET) begin
        state_nxt = jtnc_pkg::ST_START;
        err_nxt   = 1'b0;
        sp_nxt    = '0;
      end else if (in_data.mode == jtnc_pkg::MODE_CLEAR) begin
        err_nxt = 1'b0;
      end else if (in_data.mode == jtnc_pkg::MODE_TOKEN) begin
        priority if (in_data.token_kind <= jtnc_pkg::TOK_STRING) begin
          unique case (state_r)
            jtnc_pkg::ST_START: begin
              state_nxt = jtnc_pkg::ST_END;
              legal     = 1'b1;
            end
            jtnc_pkg::ST_ARRAY: begin
              legal = 1'b1;
            end
            jtnc_pkg::ST_VALUE: begin
              state_nxt = jtnc_pkg::ST_KEY;
              legal     = 1'b1;
            end
            default: legal = 1'b0;
          endcase
        end else if (in_data.token_kind == jtnc_pkg::TOK_KEY) begin
          if (state_r == jtnc_pkg::ST_KEY) begin
            state_nxt = jtnc_pkg::ST_VALUE;
            legal     = 1'b1;
          end
        end else if (in_data.token_kind == jtnc_pkg::TOK_BEGIN_ARR ||
                     in_data.token_kind == jtnc_pkg::TOK_BEGIN_OBJ) begin
          if (state_r == jtnc_pkg::ST_START || state_r == jtnc_pkg::ST_ARRAY ||
              state_r == jtnc_pkg::ST_VALUE) begin
            legal = 1'b1;
            if (full) begin
              ovf     = 1'b1;
              err_nxt = 1'b1;
            end else begin
              push      = 1'b1;
              sp_nxt    = sp_r + 1'b1;
              state_nxt = (in_data.token_kind == jtnc_pkg::TOK_BEGIN_ARR) ?
                          jtnc_pkg::ST_ARRAY : jtnc_pkg::ST_KEY;
            end
          end
        end else if ((in_data.token_kind == jtnc_pkg::TOK_END_ARR &&
                      state_r == jtnc_pkg::ST_ARRAY) ||
                     (in_data.token_kind == jtnc_pkg::TOK_END_OBJ &&
                      state_r == jtnc_pkg::ST_KEY)) begin
          legal = 1'b1;
          if (empty) begin
            err_nxt = 1'b1;
          end else begin
            sp_nxt    = sp_r - 1'b1;
            state_nxt = jtnc_pkg::pop_state(top);
          end
        end else begin
          legal = 1'b0;
        end
        if (!legal) begin
          err_nxt = 1'b1;
        end
      end else begin
        // unused mode code: no operation
        err_nxt = err_r;
      end
    end
  end

  // stack ram: write at the pointer, read the entry under the new pointer
  assign cur_code = jtnc_pkg::state_code(state_r);
  assign wr_data  = cur_code[jtnc_pkg::SAVED_W-1:0];
  assign wr_addr  = sp_r[jtnc_pkg::ADDR_W-1:0];
  assign sp_dec   = sp_nxt - 1'b1;
  assign rd_addr  = sp_dec[jtnc_pkg::ADDR_W-1:0];

  jtnc_ram #(
    .WIDTH (jtnc_pkg::SAVED_W),
    .DEPTH (jtnc_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // forward a pushed entry, the ram read of it returns the old contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= push;
    end
    fwd_data_r <= wr_data;
  end

  // grammar state and stack pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jtnc_pkg::ST_START;
      err_r   <= 1'b0;
      sp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
      sp_r    <= sp_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= accept;
    end
    if (accept) begin
      out_data_r.current_state <= jtnc_pkg::state_code(state_nxt);
      out_data_r.error_flag    <= err_nxt;
      out_data_r.nesting_depth <= jtnc_pkg::DEPTH_W'(sp_nxt);
      out_data_r.overflow      <= ovf;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= jtnc_pkg::SP_W'(jtnc_pkg::STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_ovf_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.overflow |-> out_data_r.error_flag)
    else $error("overflow reported without error flag");

  a_full_reset: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.mode == jtnc_pkg::MODE_RESET |=>
      sp_r == '0 && state_r == jtnc_pkg::ST_START && !err_r)
    else $error("full reset did not empty the stack");

  a_push_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> fwd_r && sp_r != '0)
    else $error("pushed entry not forwarded");

endmodule

>>> tb/json_token_nesting_checker_test.sv
`timescale 1ns / 100ps

module json_token_nesting_checker_test;

  localparam logic [1:0] MODE_NOP     = 2'd3;
  localparam logic [3:0] TOK_BAD_LOW  = 4'd9;
  localparam logic [3:0] TOK_BAD_HIGH = 4'd15;
  localparam int         STALL_LIMIT  = 1000;
  localparam int         TAIL_CYCLES  = 4;
  localparam int         DOC_ITEMS    = 320;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  jtnc_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  jtnc_pkg::out_item_t out_data;

  json_token_nesting_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // grammar model state
  logic [2:0]                   grammar_state = jtnc_pkg::CODE_START;
  logic                         error_seen    = 1'b0;
  logic [jtnc_pkg::SAVED_W-1:0] saved_codes [jtnc_pkg::STACK_DEPTH];
  int                           stack_level   = 0;
  jtnc_pkg::out_item_t          predicted_reports [$];
  jtnc_pkg::out_item_t          oldest;

  int tx_idle_pct     = 26;
  int rx_idle_pct     = 70;
  int doc_depth_cap   = 4;
  int items_sent      = 0;
  int reports_checked = 0;
  int overflow_hits   = 0;
  int mismatches      = 0;
  int stall_cycles    = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // states that can take a value or an opener
  function automatic logic takes_value(input logic [2:0] s);
    return (s == jtnc_pkg::CODE_START) || (s == jtnc_pkg::CODE_ARRAY) ||
           (s == jtnc_pkg::CODE_VALUE);
  endfunction

  // state after a value has been consumed
  function automatic logic [2:0] after_value(input logic [2:0] s);
    case (s)
      jtnc_pkg::CODE_START: return jtnc_pkg::CODE_END;
      jtnc_pkg::CODE_ARRAY: return jtnc_pkg::CODE_ARRAY;
      jtnc_pkg::CODE_VALUE: return jtnc_pkg::CODE_KEY;
      default:              return jtnc_pkg::CODE_START;
    endcase
  endfunction

  // apply one item to the grammar model and return the report it yields
  function automatic jtnc_pkg::out_item_t advance_grammar(input jtnc_pkg::in_item_t it);
    jtnc_pkg::out_item_t r;
    logic                legal;
    logic                full;
    logic [2:0]          s;
    legal = 1'b0;
    full  = 1'b0;
    s     = grammar_state;
    case (it.mode)
      jtnc_pkg::MODE_RESET: begin
        grammar_state = jtnc_pkg::CODE_START;
        error_seen    = 1'b0;
        stack_level   = 0;
      end
      jtnc_pkg::MODE_CLEAR: error_seen = 1'b0;
      jtnc_pkg::MODE_TOKEN: begin
        case (it.token_kind)
          jtnc_pkg::TOK_NULL, jtnc_pkg::TOK_BOOLEAN, jtnc_pkg::TOK_NUMBER,
          jtnc_pkg::TOK_STRING: begin
            if (takes_value(s)) begin
              grammar_state = after_value(s);
              legal = 1'b1;
            end
          end
          jtnc_pkg::TOK_KEY: begin
            if (s == jtnc_pkg::CODE_KEY) begin
              grammar_state = jtnc_pkg::CODE_VALUE;
              legal = 1'b1;
            end
          end
          jtnc_pkg::TOK_BEGIN_ARR, jtnc_pkg::TOK_BEGIN_OBJ: begin
            if (takes_value(s)) begin
              legal = 1'b1;
              if (stack_level >= jtnc_pkg::STACK_DEPTH) begin
                full = 1'b1;
              end else begin
                saved_codes[stack_level] = s[jtnc_pkg::SAVED_W-1:0];
                stack_level++;
                grammar_state = (it.token_kind == jtnc_pkg::TOK_BEGIN_ARR) ?
                                jtnc_pkg::CODE_ARRAY : jtnc_pkg::CODE_KEY;
              end
            end
          end
          jtnc_pkg::TOK_END_ARR, jtnc_pkg::TOK_END_OBJ: begin
            // a pop on an empty stack counts as illegal
            if (((it.token_kind == jtnc_pkg::TOK_END_ARR && s == jtnc_pkg::CODE_ARRAY) ||
                 (it.token_kind == jtnc_pkg::TOK_END_OBJ && s == jtnc_pkg::CODE_KEY)) &&
                stack_level > 0) begin
              stack_level--;
              grammar_state = after_value({1'b0, saved_codes[stack_level]});
              legal = 1'b1;
            end
          end
          default: ;
        endcase
        if (!legal || full) error_seen = 1'b1;
      end
      default: ;
    endcase
    if (full) overflow_hits++;
    r.current_state = grammar_state;
    r.error_flag    = error_seen;
    r.nesting_depth = stack_level[jtnc_pkg::DEPTH_W-1:0];
    r.overflow      = full;
    return r;
  endfunction

  function automatic logic [3:0] random_opener();
    return $urandom_range(1) ? jtnc_pkg::TOK_BEGIN_ARR : jtnc_pkg::TOK_BEGIN_OBJ;
  endfunction

  // next item of a mostly well-formed document, with some noise
  function automatic jtnc_pkg::in_item_t next_item();
    jtnc_pkg::in_item_t it;
    int                 pick;
    int                 open_pct;
    it.mode       = jtnc_pkg::MODE_TOKEN;
    it.token_kind = 4'($urandom_range(jtnc_pkg::TOK_STRING));
    if ($urandom_range(99) < 6) begin
      it.mode       = 2'($urandom_range(3));
      it.token_kind = 4'($urandom_range(15));
      return it;
    end
    pick     = $urandom_range(99);
    open_pct = (doc_depth_cap > 8) ? 85 : 50;
    case (grammar_state)
      jtnc_pkg::CODE_START: begin
        doc_depth_cap = ($urandom_range(99) < 85) ? $urandom_range(6, 1) :
                        $urandom_range(34, 28);
        if (pick < 90) it.token_kind = random_opener();
      end
      jtnc_pkg::CODE_ARRAY: begin
        if (stack_level < doc_depth_cap && pick < open_pct) it.token_kind = random_opener();
        else if (pick >= 75) it.token_kind = jtnc_pkg::TOK_END_ARR;
      end
      jtnc_pkg::CODE_KEY: begin
        if (stack_level >= doc_depth_cap || pick < ((doc_depth_cap > 8) ? 10 : 40))
          it.token_kind = jtnc_pkg::TOK_END_OBJ;
        else
          it.token_kind = jtnc_pkg::TOK_KEY;
      end
      jtnc_pkg::CODE_VALUE: begin
        if (stack_level < doc_depth_cap && pick < open_pct) it.token_kind = random_opener();
      end
      default: begin
        // document complete: stray tokens, clear or start over
        if (pick < 20) it.token_kind = 4'($urandom_range(15));
        else if (error_seen && pick < 50) it.mode = jtnc_pkg::MODE_CLEAR;
        else it.mode = jtnc_pkg::MODE_RESET;
      end
    endcase
    return it;
  endfunction

  // one input transfer, with random sender idling
  task automatic send_item(input jtnc_pkg::in_item_t it);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predicted_reports = {predicted_reports, advance_grammar(it)};
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_token(input logic [3:0] kind);
    send_item(jtnc_pkg::in_item_t'{mode: jtnc_pkg::MODE_TOKEN, token_kind: kind});
  endtask

  // hold the sender until every report has been taken
  task automatic wait_for_reports();
    in_valid <= 1'b0;
    while (predicted_reports.size() != 0) @(negedge clk);
  endtask

  // every token kind, illegal tokens, clear, reset and the unused mode
  task automatic test_grammar_directed();
    send_token(jtnc_pkg::TOK_NULL);
    send_token(jtnc_pkg::TOK_BOOLEAN);
    send_item(jtnc_pkg::in_item_t'{mode: jtnc_pkg::MODE_CLEAR, token_kind: TOK_BAD_HIGH});
    send_item(jtnc_pkg::in_item_t'{mode: jtnc_pkg::MODE_RESET, token_kind: TOK_BAD_LOW});
    send_token(jtnc_pkg::TOK_KEY);
    send_token(jtnc_pkg::TOK_END_ARR);
    send_token(jtnc_pkg::TOK_BEGIN_OBJ);
    send_token(jtnc_pkg::TOK_KEY);
    send_token(jtnc_pkg::TOK_NUMBER);
    send_token(jtnc_pkg::TOK_KEY);
    send_token(jtnc_pkg::TOK_BEGIN_ARR);
    send_token(jtnc_pkg::TOK_STRING);
    send_token(jtnc_pkg::TOK_BEGIN_OBJ);
    send_token(jtnc_pkg::TOK_END_OBJ);
    // wrong closer, out-of-range kinds, then the unused mode
    send_token(jtnc_pkg::TOK_END_OBJ);
    send_token(TOK_BAD_LOW);
    send_token(TOK_BAD_HIGH);
    send_item(jtnc_pkg::in_item_t'{mode: MODE_NOP, token_kind: TOK_BAD_HIGH});
    send_token(jtnc_pkg::TOK_END_ARR);
    send_token(jtnc_pkg::TOK_END_OBJ);
    send_item(jtnc_pkg::in_item_t'{mode: jtnc_pkg::MODE_CLEAR,
                                   token_kind: jtnc_pkg::TOK_NULL});
    send_item(jtnc_pkg::in_item_t'{mode: jtnc_pkg::MODE_RESET, token_kind: TOK_BAD_HIGH});
    send_token(jtnc_pkg::TOK_BEGIN_ARR);
    send_token(jtnc_pkg::TOK_END_ARR);
    send_item(jtnc_pkg::in_item_t'{mode: jtnc_pkg::MODE_RESET,
                                   token_kind: jtnc_pkg::TOK_NULL});
  endtask

  // nest to the full stack, push once more, then unwind to the end state
  task automatic test_stack_full();
    send_item(jtnc_pkg::in_item_t'{mode: jtnc_pkg::MODE_RESET,
                                   token_kind: 4'($urandom_range(15))});
    while (stack_level < jtnc_pkg::STACK_DEPTH) begin
      if (grammar_state == jtnc_pkg::CODE_KEY) send_token(jtnc_pkg::TOK_KEY);
      else send_token(random_opener());
    end
    if (grammar_state == jtnc_pkg::CODE_KEY) send_token(jtnc_pkg::TOK_KEY);
    send_token(random_opener());
    send_token(jtnc_pkg::TOK_STRING);
    while (stack_level > 0) begin
      case (grammar_state)
        jtnc_pkg::CODE_KEY:   send_token(jtnc_pkg::TOK_END_OBJ);
        jtnc_pkg::CODE_ARRAY: send_token(jtnc_pkg::TOK_END_ARR);
        default:              send_token(jtnc_pkg::TOK_NUMBER);
      endcase
    end
    send_item(jtnc_pkg::in_item_t'{mode: jtnc_pkg::MODE_CLEAR,
                                   token_kind: 4'($urandom_range(15))});
  endtask

  task automatic test_random_documents(input int count);
    repeat (count) send_item(next_item());
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
  end

  // compare each report with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (predicted_reports.size() == 0) begin
        $error("report with nothing pending: %p", out_data);
        mismatches++;
      end else begin
        oldest = predicted_reports.pop_front();
        reports_checked++;
        if (out_data.current_state !== oldest.current_state) begin
          $error("current_state: expected %0d, got %0d",
                 oldest.current_state, out_data.current_state);
          mismatches++;
        end
        if (out_data.error_flag !== oldest.error_flag) begin
          $error("error_flag: expected %0d, got %0d", oldest.error_flag, out_data.error_flag);
          mismatches++;
        end
        if (out_data.nesting_depth !== oldest.nesting_depth) begin
          $error("nesting_depth: expected %0d, got %0d",
                 oldest.nesting_depth, out_data.nesting_depth);
          mismatches++;
        end
        if (out_data.overflow !== oldest.overflow) begin
          $error("overflow: expected %0d, got %0d", oldest.overflow, out_data.overflow);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_grammar_directed();
    for (int round = 0; round < 3; round++) begin
      case (round)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct = 70;
        end
        1: begin
          tx_idle_pct = 70;
          rx_idle_pct = 26;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      test_stack_full();
      wait_for_reports();
      test_random_documents(DOC_ITEMS);
    end
    wait_for_reports();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d items, %0d reports checked, %0d pushes onto a full stack",
             items_sent, reports_checked, overflow_hits);
    $display("under sender-heavy, receiver-heavy and gap-free handshake idling");
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
